// ----- rtl/fvtc_pkg.sv -----
// Shared types, constants and helpers for the FAT volume type classifier.
`default_nettype none
package fvtc_pkg;

	// Packed stream widths
	localparam int IN_W  = 304;
	localparam int OUT_W = 128;

	// Root-directory division: numerator entries*32 + bytes-1 fits 22 bits
	localparam int ROOT_NUM_W = 22;
	localparam int ROOT_REM_W = 17;

	// Cluster division: 32-bit data sectors by 8-bit sectors per cluster
	localparam int CLU_NUM_W = 32;
	localparam int CLU_REM_W = 9;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	// Classification thresholds and end-of-chain marks
	localparam logic [31:0] LIMIT_FAT12 = 32'd4085;
	localparam logic [31:0] LIMIT_FAT16 = 32'd65525;
	localparam logic [27:0] EOC_FAT12   = 28'h0000FF8;
	localparam logic [27:0] EOC_FAT16   = 28'h000FFF8;
	localparam logic [27:0] EOC_FAT32   = 28'hFFFFFF8;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_FAT12   = 2'd1,
		KIND_FAT16   = 2'd2,
		KIND_FAT32   = 2'd3
	} kind_t;

	// Request handed from front to back through the queue
	typedef struct packed {
		logic [31:0] total;
		logic [31:0] meta;
		logic [7:0]  spc;
		logic        ver_nz;
		logic        ok;
	} vol_req_t;

	// Result of one volume
	typedef struct packed {
		logic [27:0] chain_end_mark;
		logic [31:0] entry_total;
		logic [31:0] data_start;
		logic [31:0] cluster_total;
		kind_t       volume_kind;
	} vol_res_t;

	// True when "FAT" starts at some byte before any zero byte
	function automatic logic label_has_fat(input logic [63:0] label);
		logic stop;
		logic hit;
		stop = 1'b0;
		hit  = 1'b0;
		for (int i = 0; i < 6; i++) begin
			if (!stop && !hit) begin
				if (label[8*i +: 8] == 8'h00) begin
					stop = 1'b1;
				end else if (label[8*i +: 8] == 8'h46 && label[8*i+8 +: 8] == 8'h41 &&
					label[8*i+16 +: 8] == 8'h54) begin
					hit = 1'b1;
				end
			end
		end
		return hit;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/fat_volume_type_classifier_top.sv -----
// Top level of the FAT volume type classifier.
`default_nettype none
// Takes one boot-sector descriptor per request on s_* and returns one result per
// request on m_*, in order. A new request can be taken every cycle while the front is
// not held by a full queue. The front (entry stage, a 22-stage root-sector divider,
// metadata sum) feeds the 4-deep queue, which feeds the back (data-sector stage,
// a 32-stage cluster divider, classification into the result register). The queue
// lets the front keep taking requests for a while when m_tready is low.
module fat_volume_type_classifier_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// sector_bytes, root_entry_count, small_fat_size, large_fat_size, small_total,
	// large_total, reserved_count, fat_copies, cluster_sectors, fs_revision,
	// label_early, label_late (lowest bits first)
	input  wire logic [fvtc_pkg::IN_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// volume_kind, cluster_total, data_start, entry_total, chain_end_mark, 2 zero bits
	output logic [fvtc_pkg::OUT_W-1:0]         m_tdata
);

	logic                           f_valid;
	logic                           f_ready;
	fvtc_pkg::vol_req_t             f_req;
	logic                           q_valid;
	logic                           q_ready;
	fvtc_pkg::vol_req_t             q_req;
	logic [fvtc_pkg::QUEUE_AW:0]    q_fill;
	fvtc_pkg::vol_res_t             res;

	fvtc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.sector_bytes     (s_tdata[15:0]),
		.root_entry_count (s_tdata[31:16]),
		.small_fat_size   (s_tdata[47:32]),
		.large_fat_size   (s_tdata[79:48]),
		.small_total      (s_tdata[95:80]),
		.large_total      (s_tdata[127:96]),
		.reserved_count   (s_tdata[143:128]),
		.fat_copies       (s_tdata[151:144]),
		.cluster_sectors  (s_tdata[159:152]),
		.fs_revision      (s_tdata[175:160]),
		.label_early      (s_tdata[239:176]),
		.label_late       (s_tdata[303:240]),
		.out_valid        (f_valid),
		.out_ready        (f_ready),
		.out_req          (f_req)
	);

	fvtc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_req    (f_req),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_req   (q_req),
		.fill      (q_fill)
	);

	fvtc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_req    (q_req),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {2'b00, res};

	// Queue never holds more than its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_fill <= (fvtc_pkg::QUEUE_AW+1)'(fvtc_pkg::QUEUE_DEPTH))
		else $error("queue fill above depth");

	// Unknown volumes carry all-zero fields
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.volume_kind == fvtc_pkg::KIND_UNKNOWN) |->
		(res.cluster_total == 32'd0 && res.data_start == 32'd0 &&
		 res.entry_total == 32'd0 && res.chain_end_mark == 28'd0))
		else $error("unknown volume with nonzero fields");

	// Entry total follows the cluster count
	a_entry_total: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.volume_kind != fvtc_pkg::KIND_UNKNOWN) |->
		(res.entry_total == res.cluster_total + 32'd2))
		else $error("entry total mismatch");

	// FAT12 only below its cluster limit
	a_fat12_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.volume_kind == fvtc_pkg::KIND_FAT12) |->
		(res.cluster_total < fvtc_pkg::LIMIT_FAT12 &&
		 res.chain_end_mark == fvtc_pkg::EOC_FAT12))
		else $error("FAT12 classification out of range");

endmodule
`default_nettype wire

// ----- rtl/fvtc_front.sv -----
// Front part: label check, field selection, root-sector divider, metadata sum.
`default_nettype none
module fvtc_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [15:0]           sector_bytes,
	input  wire logic [15:0]           root_entry_count,
	input  wire logic [15:0]           small_fat_size,
	input  wire logic [31:0]           large_fat_size,
	input  wire logic [15:0]           small_total,
	input  wire logic [31:0]           large_total,
	input  wire logic [15:0]           reserved_count,
	input  wire logic [7:0]            fat_copies,
	input  wire logic [7:0]            cluster_sectors,
	input  wire logic [15:0]           fs_revision,
	input  wire logic [63:0]           label_early,
	input  wire logic [63:0]           label_late,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output fvtc_pkg::vol_req_t         out_req
);

	localparam int Steps = fvtc_pkg::ROOT_NUM_W;
	localparam int NumW  = fvtc_pkg::ROOT_NUM_W;
	localparam int RemW  = fvtc_pkg::ROOT_REM_W;

	// Side data carried along the divider
	typedef struct packed {
		logic [31:0] prod;
		logic [31:0] total;
		logic [15:0] rsvd;
		logic [7:0]  spc;
		logic        ver_nz;
		logic        ok;
	} side_t;

	logic              en;
	logic              v_q    [0:Steps];
	logic [NumW-1:0]   num_q  [0:Steps];
	logic [RemW-1:0]   rem_q  [0:Steps];
	logic [NumW-1:0]   quo_q  [0:Steps];
	logic [15:0]       dvs_q  [0:Steps];
	side_t             side_q [0:Steps];
	logic              v_out_q;
	fvtc_pkg::vol_req_t req_q;
	logic [31:0]       fsz;
	logic              ok;

	// Whole front advances unless its finished request is blocked
	assign en       = !v_out_q || out_ready;
	assign in_ready = en;

	assign fsz = (small_fat_size != 16'd0) ? {16'd0, small_fat_size} : large_fat_size;
	assign ok  = (fvtc_pkg::label_has_fat(label_early) || fvtc_pkg::label_has_fat(label_late))
		&& sector_bytes != 16'd0 && cluster_sectors != 8'd0;

	// Entry stage: select fields, FAT area product, divider numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q[0]         <= {1'b0, root_entry_count, 5'd0} + {6'd0, sector_bytes} - 22'd1;
			rem_q[0]         <= '0;
			quo_q[0]         <= '0;
			dvs_q[0]         <= sector_bytes;
			side_q[0].prod   <= 32'(fat_copies * fsz);
			side_q[0].total  <= (small_total != 16'd0) ? {16'd0, small_total} : large_total;
			side_q[0].rsvd   <= reserved_count;
			side_q[0].spc    <= cluster_sectors;
			side_q[0].ver_nz <= (fs_revision != 16'd0);
			side_q[0].ok     <= ok;
		end
	end

	// Restoring divider, one quotient bit per stage
	for (genvar k = 0; k < Steps; k++) begin : g_div
		logic [RemW-1:0] trial;
		logic            fit;
		assign trial = {rem_q[k][RemW-2:0], num_q[k][NumW-1]};
		assign fit   = (trial >= {1'b0, dvs_q[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k+1]  <= {num_q[k][NumW-2:0], 1'b0};
				rem_q[k+1]  <= fit ? (trial - {1'b0, dvs_q[k]}) : trial;
				quo_q[k+1]  <= {quo_q[k][NumW-2:0], fit};
				dvs_q[k+1]  <= dvs_q[k];
				side_q[k+1] <= side_q[k];
			end
		end
	end

	// Output stage: first data sector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_q[Steps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_q.meta   <= {16'd0, side_q[Steps].rsvd} + side_q[Steps].prod
				+ {10'd0, quo_q[Steps]};
			req_q.total  <= side_q[Steps].total;
			req_q.spc    <= side_q[Steps].spc;
			req_q.ver_nz <= side_q[Steps].ver_nz;
			req_q.ok     <= side_q[Steps].ok;
		end
	end

	assign out_valid = v_out_q;
	assign out_req   = req_q;

endmodule
`default_nettype wire

// ----- rtl/fvtc_queue.sv -----
// Short request queue between the front and back parts.
`default_nettype none
module fvtc_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire fvtc_pkg::vol_req_t  in_req,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output fvtc_pkg::vol_req_t       out_req,
	output logic [fvtc_pkg::QUEUE_AW:0] fill
);

	localparam int Aw = fvtc_pkg::QUEUE_AW;

	fvtc_pkg::vol_req_t slot_q [0:fvtc_pkg::QUEUE_DEPTH-1];
	logic [Aw-1:0] wr_ptr_q;
	logic [Aw-1:0] rd_ptr_q;
	logic [Aw:0]   cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != (Aw+1)'(fvtc_pkg::QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_req   = slot_q[rd_ptr_q];
	assign fill      = cnt_q;

	// Pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= in_req;
	end

endmodule
`default_nettype wire

// ----- rtl/fvtc_back.sv -----
// Back part: data sectors, cluster divider, classification and result register.
`default_nettype none
module fvtc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire fvtc_pkg::vol_req_t  in_req,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output fvtc_pkg::vol_res_t       out_res
);

	localparam int Steps = fvtc_pkg::CLU_NUM_W;
	localparam int NumW  = fvtc_pkg::CLU_NUM_W;
	localparam int RemW  = fvtc_pkg::CLU_REM_W;

	typedef struct packed {
		logic [31:0] meta;
		logic        ver_nz;
		logic        ok;
	} side_t;

	logic               en;
	logic               v_q    [0:Steps];
	logic [NumW-1:0]    num_q  [0:Steps];
	logic [RemW-1:0]    rem_q  [0:Steps];
	logic [NumW-1:0]    quo_q  [0:Steps];
	logic [7:0]         dvs_q  [0:Steps];
	side_t              side_q [0:Steps];
	logic               v_out_q;
	fvtc_pkg::vol_res_t res_d;
	fvtc_pkg::vol_res_t res_q;
	logic [31:0]        clu;

	// Back advances unless the result register is held
	assign en       = !v_out_q || out_ready;
	assign in_ready = en;

	// Entry stage: data sector count, wrapped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q[0]         <= in_req.total - in_req.meta;
			rem_q[0]         <= '0;
			quo_q[0]         <= '0;
			dvs_q[0]         <= in_req.spc;
			side_q[0].meta   <= in_req.meta;
			side_q[0].ver_nz <= in_req.ver_nz;
			side_q[0].ok     <= in_req.ok;
		end
	end

	// Restoring divider, one quotient bit per stage
	for (genvar k = 0; k < Steps; k++) begin : g_div
		logic [RemW-1:0] trial;
		logic            fit;
		assign trial = {rem_q[k][RemW-2:0], num_q[k][NumW-1]};
		assign fit   = (trial >= {1'b0, dvs_q[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k+1]  <= {num_q[k][NumW-2:0], 1'b0};
				rem_q[k+1]  <= fit ? (trial - {1'b0, dvs_q[k]}) : trial;
				quo_q[k+1]  <= {quo_q[k][NumW-2:0], fit};
				dvs_q[k+1]  <= dvs_q[k];
				side_q[k+1] <= side_q[k];
			end
		end
	end

	assign clu = quo_q[Steps];

	// Classification
	always_comb begin
		res_d = '0;
		if (side_q[Steps].ok) begin
			if (clu < fvtc_pkg::LIMIT_FAT12) begin
				res_d.volume_kind    = fvtc_pkg::KIND_FAT12;
				res_d.chain_end_mark = fvtc_pkg::EOC_FAT12;
			end else if (clu < fvtc_pkg::LIMIT_FAT16) begin
				res_d.volume_kind    = fvtc_pkg::KIND_FAT16;
				res_d.chain_end_mark = fvtc_pkg::EOC_FAT16;
			end else begin
				res_d.volume_kind    = fvtc_pkg::KIND_FAT32;
				res_d.chain_end_mark = fvtc_pkg::EOC_FAT32;
			end
			res_d.cluster_total = clu;
			res_d.data_start    = side_q[Steps].meta;
			res_d.entry_total   = clu + 32'd2;
			// FAT32 with a nonzero version word stays unknown
			if (clu >= fvtc_pkg::LIMIT_FAT16 && side_q[Steps].ver_nz) begin
				res_d = '0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_q[Steps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

	assign out_valid = v_out_q;
	assign out_res   = res_q;

endmodule
`default_nettype wire

// ----- bench/fvtc_result_checker.sv -----
// Result checker for the FAT volume type classifier: predicts each request and compares results.
`timescale 1ns / 1ps
module fvtc_result_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	input  wire logic                       s_tready,
	// sector_bytes, root_entry_count, small_fat_size, large_fat_size, small_total,
	// large_total, reserved_count, fat_copies, cluster_sectors, fs_revision,
	// label_early, label_late (lowest bits first)
	input  wire logic [fvtc_pkg::IN_W-1:0]  s_tdata,
	input  wire logic                       m_tvalid,
	input  wire logic                       m_tready,
	// volume_kind, cluster_total, data_start, entry_total, chain_end_mark, 2 zero bits
	input  wire logic [fvtc_pkg::OUT_W-1:0] m_tdata,
	output int                              fail_count,
	output int                              outstanding,
	output logic [3:0][31:0]                kind_hits
);

	// Request layout, last field first so that sector_bytes lands in the low bits
	typedef struct packed {
		logic [63:0] label_late;
		logic [63:0] label_early;
		logic [15:0] fs_revision;
		logic [7:0]  cluster_sectors;
		logic [7:0]  fat_copies;
		logic [15:0] reserved_count;
		logic [31:0] large_total;
		logic [15:0] small_total;
		logic [31:0] large_fat_size;
		logic [15:0] small_fat_size;
		logic [15:0] root_entry_count;
		logic [15:0] sector_bytes;
	} volume_desc_t;

	fvtc_pkg::vol_res_t volume_results_due[$];
	fvtc_pkg::vol_res_t got;
	fvtc_pkg::vol_res_t want;
	logic [1:0]         pad;
	int                 result_index;

	initial begin
		fail_count   = 0;
		outstanding  = 0;
		kind_hits    = '0;
		result_index = 0;
	end

	// "FAT" somewhere in bytes 0..5, scanning stops at the first zero byte
	function automatic logic has_fat_tag(input logic [63:0] label);
		for (int i = 0; i < 6; i++) begin
			if (label[8*i +: 8] == 8'h00)
				return 1'b0;
			if (label[8*i +: 24] == 24'h544146)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Full classification of one boot-sector descriptor
	function automatic fvtc_pkg::vol_res_t classify_volume(input volume_desc_t d);
		fvtc_pkg::vol_res_t r;
		logic [31:0] bps;
		logic [31:0] ents;
		logic [31:0] spc;
		logic [31:0] root_secs;
		logic [31:0] fat_secs;
		logic [31:0] vol_secs;
		logic [31:0] meta_secs;
		logic [31:0] data_secs;
		logic [31:0] clusters;
		r = '0;
		r.volume_kind = fvtc_pkg::KIND_UNKNOWN;
		if (!has_fat_tag(d.label_early) && !has_fat_tag(d.label_late))
			return r;
		if (d.sector_bytes == 16'd0 || d.cluster_sectors == 8'd0)
			return r;
		bps       = {16'd0, d.sector_bytes};
		ents      = {16'd0, d.root_entry_count};
		spc       = {24'd0, d.cluster_sectors};
		root_secs = (ents * 32'd32 + bps - 32'd1) / bps;
		fat_secs  = (d.small_fat_size != 16'd0) ? {16'd0, d.small_fat_size} : d.large_fat_size;
		vol_secs  = (d.small_total != 16'd0) ? {16'd0, d.small_total} : d.large_total;
		meta_secs = {16'd0, d.reserved_count} + {24'd0, d.fat_copies} * fat_secs + root_secs;
		data_secs = vol_secs - meta_secs;
		clusters  = data_secs / spc;
		if (clusters < fvtc_pkg::LIMIT_FAT12) begin
			r.volume_kind    = fvtc_pkg::KIND_FAT12;
			r.chain_end_mark = fvtc_pkg::EOC_FAT12;
		end else if (clusters < fvtc_pkg::LIMIT_FAT16) begin
			r.volume_kind    = fvtc_pkg::KIND_FAT16;
			r.chain_end_mark = fvtc_pkg::EOC_FAT16;
		end else begin
			// FAT32 only with a zero version word
			if (d.fs_revision != 16'd0)
				return r;
			r.volume_kind    = fvtc_pkg::KIND_FAT32;
			r.chain_end_mark = fvtc_pkg::EOC_FAT32;
		end
		r.cluster_total = clusters;
		r.data_start    = meta_secs;
		r.entry_total   = clusters + 32'd2;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] seen,
		input logic [31:0] due);
		if (fail_count < 30)
			$display("%0t: result %0d, %s: got 0x%08h, expected 0x%08h",
				$time, result_index, what, seen, due);
		fail_count = fail_count + 1;
	endtask

	// Track accepted requests and check each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				volume_results_due.push_back(classify_volume(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[125:0];
				pad = m_tdata[127:126];
				if (volume_results_due.size() == 0) begin
					report_mismatch("result with no request outstanding",
						got.cluster_total, 32'd0);
				end else begin
					want = volume_results_due.pop_front();
					if (got.volume_kind !== want.volume_kind)
						report_mismatch("volume_kind", {30'd0, got.volume_kind},
							{30'd0, want.volume_kind});
					if (got.cluster_total !== want.cluster_total)
						report_mismatch("cluster_total", got.cluster_total,
							want.cluster_total);
					if (got.data_start !== want.data_start)
						report_mismatch("data_start", got.data_start, want.data_start);
					if (got.entry_total !== want.entry_total)
						report_mismatch("entry_total", got.entry_total, want.entry_total);
					if (got.chain_end_mark !== want.chain_end_mark)
						report_mismatch("chain_end_mark", {4'd0, got.chain_end_mark},
							{4'd0, want.chain_end_mark});
					if (pad !== 2'b00)
						report_mismatch("pad bits", {30'd0, pad}, 32'd0);
					if (!$isunknown(got.volume_kind))
						kind_hits[got.volume_kind] = kind_hits[got.volume_kind] + 1;
				end
				result_index = result_index + 1;
			end
			outstanding = volume_results_due.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the FAT volume type classifier: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_top;

	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          PHASE_ITEMS   = 395;
	localparam logic [63:0] TAG_FAT12     = 64'h2020_2032_3154_4146;
	localparam logic [63:0] TAG_FAT16     = 64'h2020_2036_3154_4146;
	localparam logic [63:0] TAG_FAT32     = 64'h2020_2032_3354_4146;
	localparam logic [63:0] TAG_AFTER_NUL = 64'h2020_2020_5441_4600;
	localparam logic [63:0] TAG_AT_END    = 64'h5441_4620_2020_2020;
	localparam logic [63:0] TAG_CUT_OFF   = 64'h4146_2020_2020_2020;
	localparam logic [63:0] TAG_LOWER     = 64'h2020_2020_2074_6166;

	// Request layout, last field first so that sector_bytes lands in the low bits
	typedef struct packed {
		logic [63:0] label_late;
		logic [63:0] label_early;
		logic [15:0] fs_revision;
		logic [7:0]  cluster_sectors;
		logic [7:0]  fat_copies;
		logic [15:0] reserved_count;
		logic [31:0] large_total;
		logic [15:0] small_total;
		logic [31:0] large_fat_size;
		logic [15:0] small_fat_size;
		logic [15:0] root_entry_count;
		logic [15:0] sector_bytes;
	} volume_desc_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [fvtc_pkg::IN_W-1:0]  s_tdata;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [fvtc_pkg::OUT_W-1:0] m_tdata;

	int               fail_count;
	int               outstanding;
	logic [3:0][31:0] kind_hits;
	int               cycle_count;
	int               n_sent;
	int               send_idle_pct;
	int               recv_stall_pct;
	int               hold_asked;
	int               hold_done;

	fat_volume_type_classifier_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	fvtc_result_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.kind_hits   (kind_hits)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, outstanding);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Output side: random stalls, plus a long hold-off whenever one is requested
	initial begin
		m_tready  = 1'b0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_done) begin
				hold_done = hold_asked;
				m_tready  = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic volume_desc_t mk_volume(input logic [15:0] bps, input logic [15:0] ents,
		input logic [15:0] fat16, input logic [31:0] fat32, input logic [15:0] tot16,
		input logic [31:0] tot32, input logic [15:0] rsvd, input logic [7:0] copies,
		input logic [7:0] spc, input logic [15:0] ver, input logic [63:0] lab_e,
		input logic [63:0] lab_l);
		volume_desc_t d;
		d.sector_bytes     = bps;
		d.root_entry_count = ents;
		d.small_fat_size   = fat16;
		d.large_fat_size   = fat32;
		d.small_total      = tot16;
		d.large_total      = tot32;
		d.reserved_count   = rsvd;
		d.fat_copies       = copies;
		d.cluster_sectors  = spc;
		d.fs_revision      = ver;
		d.label_early      = lab_e;
		d.label_late       = lab_l;
		return d;
	endfunction

	// Random label with "FAT" at byte pos and no zero byte ahead of it
	function automatic logic [63:0] tag_label(input int pos);
		logic [63:0] lab;
		for (int b = 0; b < 8; b++)
			lab[8*b +: 8] = (b < pos) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255));
		lab[8*pos +: 24] = 24'h544146;
		return lab;
	endfunction

	// Mostly plausible geometries steered toward each cluster range, the rest raw noise
	function automatic volume_desc_t random_volume();
		volume_desc_t d;
		int           pos;
		logic [31:0]  root_secs;
		logic [31:0]  fat_secs;
		logic [31:0]  meta_secs;
		logic [31:0]  target;
		logic [31:0]  vol_secs;
		d = '0;
		d.label_early = {$urandom, $urandom};
		d.label_late  = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2: d.label_early = tag_label($urandom_range(0, 5));
			3, 4, 5: d.label_late = tag_label($urandom_range(0, 5));
			6: begin
				d.label_early = tag_label($urandom_range(0, 5));
				d.label_late  = tag_label($urandom_range(0, 5));
			end
			8: begin
				// tag hidden behind a zero byte
				pos = $urandom_range(1, 5);
				d.label_early = tag_label(pos);
				d.label_early[8*(pos-1) +: 8] = 8'h00;
				d.label_late[7:0] = 8'h00;
			end
			9: begin
				// only "FA" fits at the end
				d.label_early[63:48] = 16'h4146;
				d.label_late[7:0] = 8'h00;
			end
			default: ;
		endcase
		if ($urandom_range(0, 9) < 7) begin
			d.sector_bytes = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535)) :
				16'd1 << $urandom_range(5, 12);
			d.cluster_sectors = 8'd1 << $urandom_range(0, 7);
			d.root_entry_count = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
				16'($urandom_range(0, 1024));
			d.reserved_count = 16'($urandom_range(1, 64));
			d.fat_copies     = 8'($urandom_range(1, 4));
			d.large_fat_size = $urandom;
			if ($urandom_range(0, 1) == 0) begin
				d.small_fat_size = 16'($urandom_range(1, 4096));
			end else begin
				d.small_fat_size = 16'd0;
				d.large_fat_size = $urandom_range(1, 20000);
			end
			d.fs_revision = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) :
				16'd0;
			root_secs = ({16'd0, d.root_entry_count} * 32'd32 + {16'd0, d.sector_bytes}
				- 32'd1) / {16'd0, d.sector_bytes};
			fat_secs  = (d.small_fat_size != 16'd0) ? {16'd0, d.small_fat_size} :
				d.large_fat_size;
			meta_secs = {16'd0, d.reserved_count} + {24'd0, d.fat_copies} * fat_secs
				+ root_secs;
			case ($urandom_range(0, 4))
				0: target = fvtc_pkg::LIMIT_FAT12 - 32'd3 + $urandom_range(0, 5);
				1: target = fvtc_pkg::LIMIT_FAT16 - 32'd3 + $urandom_range(0, 5);
				2: target = $urandom_range(0, 4084);
				3: target = $urandom_range(4085, 65524);
				default: target = $urandom_range(65525, 24'hFFFFFF);
			endcase
			vol_secs = meta_secs + target * {24'd0, d.cluster_sectors}
				+ $urandom_range(0, d.cluster_sectors - 1);
			d.large_total = $urandom;
			if (vol_secs < 32'd65536 && vol_secs != 32'd0 && $urandom_range(0, 1) == 0) begin
				d.small_total = vol_secs[15:0];
			end else begin
				d.small_total = 16'd0;
				d.large_total = vol_secs;
			end
		end else begin
			d.sector_bytes     = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
			d.root_entry_count = 16'($urandom);
			d.small_fat_size   = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
			d.large_fat_size   = $urandom;
			d.small_total      = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
			d.large_total      = $urandom;
			d.reserved_count   = 16'($urandom);
			d.fat_copies       = 8'($urandom);
			d.cluster_sectors  = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
			d.fs_revision      = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
		end
		return d;
	endfunction

	// Offer one request after a random number of idle cycles, hold it until taken
	task automatic send_volume(input volume_desc_t d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = d;
		do @(posedge clk); while (!s_tready);
		n_sent = n_sent + 1;
	endtask

	// Stop offering and wait for every predicted result
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Main stimulus
	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_asked     = 0;
		n_sent         = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, every kind, each unknown path and wrap case
		send_volume(mk_volume(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 64'd0, 64'd0));
		send_volume(mk_volume('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
		send_volume(mk_volume('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, TAG_FAT32, '1));
		send_volume(mk_volume('1, '1, 0, '1, 0, '1, '1, '1, '1, 0, TAG_FAT16, '1));
		// floppy-style FAT12 and a FAT16 named only in the late label
		send_volume(mk_volume(512, 224, 9, 0, 2880, 0, 1, 2, 1, 0, TAG_FAT12, 64'd0));
		send_volume(mk_volume(512, 512, 200, 0, 0, 100000, 1, 2, 2, 0, 64'd0, TAG_FAT16));
		// FAT32 with zero and nonzero version; version ignored below FAT32
		send_volume(mk_volume(512, 0, 0, 1000, 0, 4000000, 32, 2, 8, 0, 64'd0, TAG_FAT32));
		send_volume(mk_volume(512, 0, 0, 1000, 0, 4000000, 32, 2, 8, 16'h0001, 64'd0,
			TAG_FAT32));
		send_volume(mk_volume(512, 224, 9, 0, 2880, 0, 1, 2, 1, 16'hFFFF, TAG_FAT12, 64'd0));
		// zero sector size, zero cluster size
		send_volume(mk_volume(0, 224, 9, 0, 2880, 0, 1, 2, 1, 0, TAG_FAT12, 64'd0));
		send_volume(mk_volume(512, 224, 9, 0, 2880, 0, 1, 2, 0, 0, TAG_FAT12, 64'd0));
		// metadata beyond the volume, data_start wrap, entry_total wrap
		send_volume(mk_volume(512, 0, 1, 0, 100, 0, 200, 1, 1, 0, TAG_FAT12, 64'd0));
		send_volume(mk_volume(1, 65535, 0, '1, 0, 32'd5, 65535, 255, 1, 0, TAG_FAT32, 64'd0));
		send_volume(mk_volume(512, 0, 1, 0, 0, 0, 1, 0, 1, 0, TAG_FAT32, 64'd0));
		// cluster-count thresholds
		send_volume(mk_volume(512, 0, 1, 0, 4084, 0, 0, 0, 1, 0, TAG_FAT12, 64'd0));
		send_volume(mk_volume(512, 0, 1, 0, 4085, 0, 0, 0, 1, 0, TAG_FAT12, 64'd0));
		send_volume(mk_volume(512, 0, 1, 0, 65524, 0, 0, 0, 1, 0, TAG_FAT16, 64'd0));
		send_volume(mk_volume(512, 0, 1, 0, 0, 65525, 0, 0, 1, 0, TAG_FAT32, 64'd0));
		// label edge cases: tag after a zero byte, tag in the last three bytes,
		// tag cut off by the end, lower case
		send_volume(mk_volume(512, 224, 9, 0, 2880, 0, 1, 2, 1, 0, TAG_AFTER_NUL, 64'd0));
		send_volume(mk_volume(512, 224, 9, 0, 2880, 0, 1, 2, 1, 0, TAG_AT_END, 64'd0));
		send_volume(mk_volume(512, 224, 9, 0, 2880, 0, 1, 2, 1, 0, TAG_CUT_OFF, TAG_CUT_OFF));
		send_volume(mk_volume(512, 224, 9, 0, 2880, 0, 1, 2, 1, 0, TAG_LOWER, TAG_LOWER));
		send_volume(mk_volume(1, 65535, 0, 3, 0, '1, 7, 3, 255, 0, 64'd0, TAG_AT_END));
		drain_results();

		// Random requests under four flow-control mixes
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long output hold-off while requests keep coming back to back
				if (phase == 0 && i == 100)
					hold_asked = hold_asked + 1;
				if (phase == 1 && i == 200)
					drain_results();
				send_volume(random_volume());
			end
			drain_results();
		end

		repeat (100) @(posedge clk);
		$display("Sent %0d volume descriptors under four idle/stall mixes,", n_sent);
		$display("with one long output hold-off and a full drain after each phase.");
		$display("Results seen: unknown %0d, FAT12 %0d, FAT16 %0d, FAT32 %0d; %0d failures.",
			kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], fail_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
